FILE: rtl/esc_pkg.sv
// shared types, constants and helper functions of the epoch seconds to calendar converter
package esc_pkg;

    // time and calendar constants
    localparam int SECS_PER_MIN  = 60;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_DAY  = 86400;
    localparam int DAYS_PER_YEAR = 365;
    localparam int MONTHS        = 12;

    // pipeline depth: three constant dividers of three stages each in series
    localparam int STAGES = 9;

    // field and intermediate widths
    localparam int W_EPOCH = 32;
    localparam int W_SEC   = 6;
    localparam int W_MIN   = 6;
    localparam int W_HOUR  = 5;
    localparam int W_DOM   = 5;
    localparam int W_MONTH = 4;
    localparam int W_YEAR  = 8;
    localparam int W_DAYS  = 16;
    localparam int W_SOD   = 17;
    localparam int W_SOH   = 12;
    localparam int W_DOY   = 9;

    typedef logic [W_EPOCH-1:0] t_epoch;
    typedef logic [W_SEC-1:0]   t_sec;
    typedef logic [W_MIN-1:0]   t_min;
    typedef logic [W_HOUR-1:0]  t_hour;
    typedef logic [W_DOM-1:0]   t_dom;
    typedef logic [W_MONTH-1:0] t_month;
    typedef logic [W_YEAR-1:0]  t_year;
    typedef logic [W_DOY-1:0]   t_doy;

    // load enables of one three-stage section
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage3_en;

    // load enables of the whole pipeline, bit i loads stage i
    typedef struct packed {
        logic [STAGES-1:0] ld;
    } t_pipe_ctl;

    // zero-based first day of each month in a common year
    function automatic t_doy month_start(input logic [W_MONTH-1:0] idx);
        t_doy b;
        case (idx)
            4'd0:    b = 9'd0;
            4'd1:    b = 9'd31;
            4'd2:    b = 9'd59;
            4'd3:    b = 9'd90;
            4'd4:    b = 9'd120;
            4'd5:    b = 9'd151;
            4'd6:    b = 9'd181;
            4'd7:    b = 9'd212;
            4'd8:    b = 9'd243;
            4'd9:    b = 9'd273;
            4'd10:   b = 9'd304;
            4'd11:   b = 9'd334;
            default: b = 9'd0;
        endcase
        return b;
    endfunction

    // leap days in the years before year offset y, every fourth year counted
    function automatic t_year leap_days_before(input t_year y);
        t_year n;
        if (y == '0) begin
            n = '0;
        end else begin
            n = ((y - 8'd1) >> 2) + 8'd1;
        end
        return n;
    endfunction

endpackage

FILE: rtl/esc_in_if.sv
// stream interface carrying one epoch timestamp per transfer
interface esc_in_if;
    import esc_pkg::*;

    logic   valid;
    logic   ready;
    t_epoch seconds_since_epoch;

    modport source (output valid, output seconds_since_epoch, input ready);
    modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

FILE: rtl/esc_out_if.sv
// stream interface carrying one calendar date and time per transfer
interface esc_out_if;
    import esc_pkg::*;

    logic   valid;
    logic   ready;
    t_sec   second_of_minute;
    t_min   minute_of_hour;
    t_hour  hour_of_day;
    t_dom   day_of_month;
    t_month month_of_year;
    t_year  year_offset;

    modport source (
        output valid, output second_of_minute, output minute_of_hour,
        output hour_of_day, output day_of_month, output month_of_year,
        output year_offset, input ready
    );
    modport sink (
        input valid, input second_of_minute, input minute_of_hour,
        input hour_of_day, input day_of_month, input month_of_year,
        input year_offset, output ready
    );
endinterface

FILE: rtl/esc_ctl.sv
// valid bits and per-stage load enables of the converter pipeline
module esc_ctl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_ready,
    output logic              o_ready,
    output logic              o_valid,
    output esc_pkg::t_pipe_ctl o_ctl
);
    import esc_pkg::*;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] n_v;
    logic [STAGES:0]   rdy;

    // a stage takes new data when empty or when its content moves on
    always_comb begin
        rdy[STAGES] = i_ready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            rdy[i] = !r_v[i] || rdy[i+1];
        end
        n_v = r_v;
        if (rdy[0]) begin
            n_v[0] = i_valid;
        end
        for (int i = 1; i < STAGES; i++) begin
            if (rdy[i]) begin
                n_v[i] = r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_ready   = rdy[0];
    assign o_valid   = r_v[STAGES-1];
    assign o_ctl.ld  = rdy[STAGES-1:0];

endmodule

FILE: rtl/esc_cdiv.sv
// three-stage divider by a constant: reciprocal multiply, back-multiply, one correction
module esc_cdiv #(
    parameter int XW = 32,
    parameter int D  = 86400,
    parameter int K  = 32,
    parameter int QW = 16,
    parameter int RW = 17
) (
    input  logic                i_clk,
    input  esc_pkg::t_stage3_en i_en,
    input  logic [XW-1:0]       i_x,
    output logic [QW-1:0]       o_q,
    output logic [RW-1:0]       o_r
);
    import esc_pkg::*;

    localparam int DW = $clog2(D);
    localparam int MW = K - DW + 1;
    localparam int PW = XW + MW;
    // floor of 2^K / D: the estimate is never high and at most one low
    localparam logic [MW-1:0] M   = MW'((64'd1 << K) / D);
    localparam logic [XW-1:0] D_X = XW'(D);

    logic [XW-1:0] r_x_a;
    logic [PW-1:0] r_p;
    logic [XW-1:0] r_x_b;
    logic [QW-1:0] r_qe;
    logic [XW-1:0] r_qd;
    logic [QW-1:0] r_q;
    logic [RW-1:0] r_r;

    logic [QW-1:0] q_est;
    logic [XW-1:0] diff;
    logic [XW:0]   diff2;
    logic [QW-1:0] n_q;
    logic [RW-1:0] n_r;

    assign q_est = r_p[K+QW-1:K];

    always_comb begin
        diff  = r_x_b - r_qd;
        diff2 = {1'b0, diff} - {1'b0, D_X};
        if (diff2[XW]) begin
            n_q = r_qe;
            n_r = diff[RW-1:0];
        end else begin
            n_q = r_qe + 1'b1;
            n_r = diff2[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_x_a <= i_x;
            r_p   <= {{MW{1'b0}}, i_x} * {{XW{1'b0}}, M};
        end
        if (i_en.s2) begin
            r_x_b <= r_x_a;
            r_qe  <= q_est;
            r_qd  <= XW'({{XW{1'b0}}, q_est} * D_X);
        end
        if (i_en.s3) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_q = r_q;
    assign o_r = r_r;

endmodule

FILE: rtl/esc_date.sv
// leap-day correction of the year estimate, month search and day of month
module esc_date (
    input  logic                i_clk,
    input  esc_pkg::t_stage3_en i_en,
    input  esc_pkg::t_year      i_year_est,
    input  esc_pkg::t_doy       i_doy_est,
    output esc_pkg::t_year      o_year,
    output esc_pkg::t_month     o_month,
    output esc_pkg::t_dom       o_dom
);
    import esc_pkg::*;

    t_year  r_year_a;
    t_doy   r_doy_a;
    t_year  r_year_b;
    t_doy   r_doy_b;
    t_month r_month_b;
    t_doy   r_bound_b;
    t_year  r_year_c;
    t_month r_month_c;
    t_dom   r_dom_c;

    t_year  lead;
    t_year  lead_prev;
    t_year  n_year;
    t_doy   n_doy;
    logic   leap;
    t_doy   b;
    t_month n_month;
    t_doy   n_bound;

    // stage one: subtract the leap days, or step back a year when they do not fit
    always_comb begin
        lead      = leap_days_before(i_year_est);
        lead_prev = leap_days_before(i_year_est - 8'd1);
        if (i_doy_est >= {1'b0, lead}) begin
            n_year = i_year_est;
            n_doy  = i_doy_est - {1'b0, lead};
        end else begin
            n_year = i_year_est - 8'd1;
            n_doy  = W_DOY'({1'b0, i_doy_est} + 10'(DAYS_PER_YEAR) - {2'b00, lead_prev});
        end
    end

    // stage two: last month whose first day is not after the day of year
    always_comb begin
        leap    = (r_year_a[1:0] == 2'b00);
        n_month = 4'd1;
        n_bound = '0;
        for (int i = 1; i < MONTHS; i++) begin
            b = month_start(W_MONTH'(i)) + ((i >= 2) ? {8'd0, leap} : 9'd0);
            if (r_doy_a >= b) begin
                n_month = W_MONTH'(i + 1);
                n_bound = b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_year_a <= n_year;
            r_doy_a  <= n_doy;
        end
        if (i_en.s2) begin
            r_year_b  <= r_year_a;
            r_doy_b   <= r_doy_a;
            r_month_b <= n_month;
            r_bound_b <= n_bound;
        end
        if (i_en.s3) begin
            r_year_c  <= r_year_b;
            r_month_c <= r_month_b;
            r_dom_c   <= W_DOM'(r_doy_b - r_bound_b + 9'd1);
        end
    end

    assign o_year  = r_year_c;
    assign o_month = r_month_c;
    assign o_dom   = r_dom_c;

endmodule

FILE: rtl/epoch_seconds_to_calendar_core.sv
// top level of the epoch seconds to calendar date converter
//
// Converts an unsigned 32-bit count of seconds since midnight 1 January 2000 into
// second, minute, hour, day of month, month (January is 1) and year offset from
// 2000 (calendar year = offset + 2000). Every fourth year is taken as a leap year,
// so dates match the Gregorian calendar through 2099; 2100 is treated as a leap
// year. The converter takes one timestamp every clock cycle unless the output
// stalls, and returns the results in order. The pipeline is three divisions by a
// constant in series (seconds per day, then seconds per hour alongside days per
// year, then seconds per minute alongside the month search), each spread over
// three register stages. Back-pressure on the output stalls only the stages that
// hold data, so empty stages keep filling while a result waits.
module epoch_seconds_to_calendar_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    esc_in_if.sink     i_sec,
    esc_out_if.source  o_cal
);
    import esc_pkg::*;

    t_pipe_ctl ctl;
    logic      out_valid;

    // stage enables of the three sections
    t_stage3_en en_a;
    t_stage3_en en_b;
    t_stage3_en en_c;

    // section a outputs: whole days and second of day
    logic [W_DAYS-1:0] days;
    logic [W_SOD-1:0]  sod;

    // section b outputs: hour with second of hour, year estimate with day of year
    t_hour             hour_b;
    logic [W_SOH-1:0]  soh;
    t_year             year_est;
    t_doy              doy_est;

    // section c outputs
    t_min   min_c;
    t_sec   sec_c;
    t_year  year_c;
    t_month month_c;
    t_dom   dom_c;

    // hour travels alongside section c
    t_hour r_hour_c1;
    t_hour r_hour_c2;
    t_hour r_hour_c3;

    // pipeline control: valid bits and bubble-filling load enables
    esc_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_sec.valid),
        .i_ready (o_cal.ready),
        .o_ready (i_sec.ready),
        .o_valid (out_valid),
        .o_ctl   (ctl)
    );

    assign en_a = '{s1: ctl.ld[0], s2: ctl.ld[1], s3: ctl.ld[2]};
    assign en_b = '{s1: ctl.ld[3], s2: ctl.ld[4], s3: ctl.ld[5]};
    assign en_c = '{s1: ctl.ld[6], s2: ctl.ld[7], s3: ctl.ld[8]};

    // section a: seconds into days and second of day
    esc_cdiv #(
        .XW (W_EPOCH),
        .D  (SECS_PER_DAY),
        .K  (W_EPOCH),
        .QW (W_DAYS),
        .RW (W_SOD)
    ) u_div_day (
        .i_clk (i_clk),
        .i_en  (en_a),
        .i_x   (i_sec.seconds_since_epoch),
        .o_q   (days),
        .o_r   (sod)
    );

    // section b: hour of day
    esc_cdiv #(
        .XW (W_SOD),
        .D  (SECS_PER_HOUR),
        .K  (W_SOD),
        .QW (W_HOUR),
        .RW (W_SOH)
    ) u_div_hour (
        .i_clk (i_clk),
        .i_en  (en_b),
        .i_x   (sod),
        .o_q   (hour_b),
        .o_r   (soh)
    );

    // section b: year estimate from whole common years
    esc_cdiv #(
        .XW (W_DAYS),
        .D  (DAYS_PER_YEAR),
        .K  (W_DAYS),
        .QW (W_YEAR),
        .RW (W_DOY)
    ) u_div_year (
        .i_clk (i_clk),
        .i_en  (en_b),
        .i_x   (days),
        .o_q   (year_est),
        .o_r   (doy_est)
    );

    // section c: minute and second
    esc_cdiv #(
        .XW (W_SOH),
        .D  (SECS_PER_MIN),
        .K  (W_SOH),
        .QW (W_MIN),
        .RW (W_SEC)
    ) u_div_min (
        .i_clk (i_clk),
        .i_en  (en_c),
        .i_x   (soh),
        .o_q   (min_c),
        .o_r   (sec_c)
    );

    // section c: leap correction and month search
    esc_date u_date (
        .i_clk      (i_clk),
        .i_en       (en_c),
        .i_year_est (year_est),
        .i_doy_est  (doy_est),
        .o_year     (year_c),
        .o_month    (month_c),
        .o_dom      (dom_c)
    );

    always_ff @(posedge i_clk) begin
        if (en_c.s1) begin
            r_hour_c1 <= hour_b;
        end
        if (en_c.s2) begin
            r_hour_c2 <= r_hour_c1;
        end
        if (en_c.s3) begin
            r_hour_c3 <= r_hour_c2;
        end
    end

    // last stage registers are the output register
    assign o_cal.valid            = out_valid;
    assign o_cal.second_of_minute = sec_c;
    assign o_cal.minute_of_hour   = min_c;
    assign o_cal.hour_of_day      = r_hour_c3;
    assign o_cal.day_of_month     = dom_c;
    assign o_cal.month_of_year    = month_c;
    assign o_cal.year_offset      = year_c;

    // an empty output stage means every stage can take data
    a_ready_when_drained: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_cal.valid |-> i_sec.ready
    ) else $error("input not ready while output stage empty");

    // every delivered field lies within its calendar range
    a_field_ranges: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_cal.valid |-> (o_cal.second_of_minute < 6'd60) && (o_cal.minute_of_hour < 6'd60)
            && (o_cal.hour_of_day < 5'd24) && (o_cal.day_of_month != 5'd0)
            && (o_cal.month_of_year != 4'd0) && (o_cal.month_of_year <= 4'd12)
            && (o_cal.year_offset <= 8'd136)
    ) else $error("calendar field out of range");

    // february never passes day 29
    a_february_length: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_cal.valid && (o_cal.month_of_year == 4'd2) |-> (o_cal.day_of_month <= 5'd29)
    ) else $error("february day out of range");

    // thirty-day months never reach day 31
    a_short_month_length: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_cal.valid && ((o_cal.month_of_year == 4'd4) || (o_cal.month_of_year == 4'd6)
            || (o_cal.month_of_year == 4'd9) || (o_cal.month_of_year == 4'd11))
        |-> (o_cal.day_of_month <= 5'd30)
    ) else $error("thirty-day month day out of range");

endmodule

FILE: sim/tb.sv
// self-checking testbench of the epoch seconds to calendar converter
`timescale 1ns / 100ps

module tb;
    import esc_pkg::*;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 9;
    localparam int          RANDOM_STAMPS  = 1325;
    localparam int          PHASE_LEN      = 110;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int unsigned DAY_SECS       = 86400;
    localparam int unsigned MAX_DAYS       = 49710;

    // zero-based first day of each month, common year
    localparam int unsigned FIRST_DAY [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    // directed timestamps: field extremes, leap days, year estimate one too high,
    // 2100 taken as leap, largest input
    localparam t_epoch CORNER_STAMPS [26] = '{
        32'd0,          32'd59,         32'd60,         32'd3599,
        32'd3600,       32'd86399,      32'd86400,
        32'd5011200,    32'd5097600,    32'd5184000,
        32'd31535999,   32'd31536000,   32'd31622399,   32'd31622400,
        32'd126144000,  32'd126230399,  32'd126230400,
        32'd3160771200, 32'd3160857600, 32'd3160944000,
        32'h7FFFFFFF,   32'h80000000,   32'hAAAAAAAA,   32'h55555555,
        32'hFFFFFFFE,   32'hFFFFFFFF
    };

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_phase;

    typedef struct packed {
        t_sec   second_of_minute;
        t_min   minute_of_hour;
        t_hour  hour_of_day;
        t_dom   day_of_month;
        t_month month_of_year;
        t_year  year_offset;
    } t_cal_date;

    class t_calendar_scoreboard;
        t_cal_date   pending_dates[$];
        int unsigned errors = 0;

        // leap days before a year offset, every fourth year counted
        function int unsigned leaps_before(int unsigned y);
            return (y == 0) ? 0 : (y - 1) / 4 + 1;
        endfunction

        function t_cal_date to_calendar(t_epoch stamp);
            int unsigned rest, days, year, doy, lead, leap, month, bound, b, m;
            t_cal_date   r;
            r.second_of_minute = t_sec'(stamp % 60);
            rest               = stamp / 60;
            r.minute_of_hour   = t_min'(rest % 60);
            rest               = rest / 60;
            r.hour_of_day      = t_hour'(rest % 24);
            days               = rest / 24;
            year = days / 365;
            doy  = days - year * 365;
            lead = leaps_before(year);
            if (doy >= lead) begin
                doy = doy - lead;
            end else begin
                // estimate was one year too high
                year = year - 1;
                doy  = doy + 365 - leaps_before(year);
            end
            leap  = (year % 4 == 0) ? 1 : 0;
            month = 1;
            bound = 0;
            for (m = 1; m < 12; m++) begin
                b = FIRST_DAY[m] + ((m >= 2) ? leap : 0);
                if (doy >= b) begin
                    month = m + 1;
                    bound = b;
                end
            end
            r.day_of_month  = t_dom'(doy - bound + 1);
            r.month_of_year = t_month'(month);
            r.year_offset   = t_year'(year);
            return r;
        endfunction

        function void note_timestamp(t_epoch stamp);
            pending_dates.push_back(to_calendar(stamp));
        endfunction

        function void check_date(t_cal_date got);
            t_cal_date exp_d;
            if (pending_dates.size() == 0) begin
                $error("result with nothing outstanding: %p", got);
                errors++;
                return;
            end
            exp_d = pending_dates.pop_front();
            if (got.second_of_minute !== exp_d.second_of_minute) begin
                $error("second_of_minute: expected %0d, got %0d",
                       exp_d.second_of_minute, got.second_of_minute);
                errors++;
            end
            if (got.minute_of_hour !== exp_d.minute_of_hour) begin
                $error("minute_of_hour: expected %0d, got %0d",
                       exp_d.minute_of_hour, got.minute_of_hour);
                errors++;
            end
            if (got.hour_of_day !== exp_d.hour_of_day) begin
                $error("hour_of_day: expected %0d, got %0d",
                       exp_d.hour_of_day, got.hour_of_day);
                errors++;
            end
            if (got.day_of_month !== exp_d.day_of_month) begin
                $error("day_of_month: expected %0d, got %0d",
                       exp_d.day_of_month, got.day_of_month);
                errors++;
            end
            if (got.month_of_year !== exp_d.month_of_year) begin
                $error("month_of_year: expected %0d, got %0d",
                       exp_d.month_of_year, got.month_of_year);
                errors++;
            end
            if (got.year_offset !== exp_d.year_offset) begin
                $error("year_offset: expected %0d, got %0d",
                       exp_d.year_offset, got.year_offset);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_dates.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    esc_in_if             sec_bus ();
    esc_out_if            cal_bus ();
    t_calendar_scoreboard sb = new();
    int unsigned          src_idle_pct  = 0;
    int unsigned          snk_stall_pct = 0;
    int unsigned          idle_cycles   = 0;

    epoch_seconds_to_calendar_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sec   (sec_bus),
        .o_cal   (cal_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    task automatic set_idle_phase(t_idle_phase phase);
        case (phase)
            IDLE_NONE: begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            IDLE_SENDER: begin
                src_idle_pct  = 46;
                snk_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                src_idle_pct  = 0;
                snk_stall_pct = 46;
            end
            default: begin
                src_idle_pct  = 7;
                snk_stall_pct = 7;
            end
        endcase
    endtask

    // one transfer in, with random idle cycles ahead of it
    task automatic send_timestamp(t_epoch stamp);
        while ($urandom_range(99) < src_idle_pct) begin
            sec_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        sec_bus.valid               <= 1'b1;
        sec_bus.seconds_since_epoch <= stamp;
        do @(posedge i_clk); while (sec_bus.ready !== 1'b1);
        sb.note_timestamp(stamp);
    endtask

    // sender holds off until every outstanding date has come out
    task automatic drain_results();
        sec_bus.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // mix of raw words, random instants on random days and instants near year starts
    function automatic t_epoch random_stamp();
        int unsigned pick, y, days;
        int          delta;
        pick = $urandom_range(99);
        if (pick < 40) begin
            return $urandom;
        end else if (pick < 70) begin
            days = $urandom_range(MAX_DAYS - 1, 0);
            return t_epoch'(days) * DAY_SECS + t_epoch'($urandom_range(DAY_SECS - 1, 0));
        end else begin
            y     = $urandom_range(135, 1);
            delta = int'($urandom_range(4, 0)) - 2;
            days  = 365 * y + sb.leaps_before(y) + delta;
            return t_epoch'(days) * DAY_SECS +
                   ($urandom_range(1, 0) ? t_epoch'(DAY_SECS - 1)
                                         : t_epoch'($urandom_range(DAY_SECS - 1, 0)));
        end
    endfunction

    // receiver: check on each output transfer, then pick the next ready
    initial begin
        cal_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (cal_bus.valid === 1'b1 && cal_bus.ready === 1'b1) begin
                sb.check_date('{cal_bus.second_of_minute, cal_bus.minute_of_hour,
                                cal_bus.hour_of_day, cal_bus.day_of_month,
                                cal_bus.month_of_year, cal_bus.year_offset});
            end
            cal_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // watchdog: too many cycles without any transfer ends the run
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((sec_bus.valid === 1'b1 && sec_bus.ready === 1'b1) ||
                (cal_bus.valid === 1'b1 && cal_bus.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int n;
        i_rst_n                     <= 1'b0;
        sec_bus.valid               <= 1'b0;
        sec_bus.seconds_since_epoch <= '0;
        set_idle_phase(IDLE_NONE);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (CORNER_STAMPS[k]) send_timestamp(CORNER_STAMPS[k]);

        for (n = 0; n < RANDOM_STAMPS; n++) begin
            if (n % PHASE_LEN == 0) begin
                drain_results();
                @(posedge i_clk);
                set_idle_phase(t_idle_phase'((n / PHASE_LEN) % 4));
            end
            send_timestamp(random_stamp());
        end

        drain_results();
        repeat (4 * STAGES) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
